// ===== hdl/acs_pkg.sv =====
// Shared types, constants and codes of the ADC conversion scaler.
// No dependencies; every module of the block imports this package.
package acs_pkg;

    // Store geometry
    localparam int NumChannels = 16;
    localparam int SampleBits  = 16;
    localparam int StoreW      = (SampleBits >= 16) ? 16 : SampleBits;
    localparam int ChFieldW    = 4;
    localparam int ChIdxW      = (NumChannels > 1) ? $clog2(NumChannels) : 1;

    // Datapath widths
    localparam int MvW    = 16;                 // millivolt fields and registers
    localparam int GainW  = 8;
    localparam int MagW   = StoreW + GainW;     // |pos - neg| * gain
    localparam int DivW   = MagW + 10;          // magnitude times the 10-bit scale
    localparam int DivCntW = $clog2(DivW);
    localparam int ResW   = 10;
    localparam int WordW  = 16;
    localparam int CfgIdxW = 2;

    // Queue between front and back
    localparam int QueueDepth = 2;
    localparam int QPtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCntW  = $clog2(QueueDepth + 1);

    // Scaling constants
    localparam logic [MvW-1:0]  VrefDefault   = MvW'(3300);
    localparam logic [ResW-1:0] Scale9        = 10'h1ff;
    localparam logic [ResW-1:0] Scale10       = 10'h3ff;
    localparam logic [ResW-1:0] NegClip       = 10'h200;
    localparam int              AdjShift      = 6;
    localparam int              VccQuarterSh  = 2;   // VCC/4

    typedef enum logic [1:0] {
        OP_WRITE_CH   = 2'd0,
        OP_WRITE_TEMP = 2'd1,
        OP_CONVERT    = 2'd2,
        OP_IGNORE     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        MUX_SINGLE      = 3'd0,
        MUX_DIFF        = 3'd1,
        MUX_TEMP        = 3'd2,
        MUX_FIXED       = 3'd3,
        MUX_VCC_QUARTER = 3'd4
    } t_mux_kind;

    typedef enum logic [1:0] {
        REF_VCC   = 2'd0,
        REF_AREF  = 2'd1,
        REF_AVCC  = 2'd2,
        REF_FIXED = 2'd3
    } t_ref_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_VCC  = 2'd0,
        CFG_AREF = 2'd1,
        CFG_AVCC = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        BS_IDLE = 2'd0,
        BS_DIV  = 2'd1,
        BS_DONE = 2'd2
    } t_back_state;

    typedef struct packed {
        logic [MvW-1:0] vcc;
        logic [MvW-1:0] aref;
        logic [MvW-1:0] avcc;
    } t_cfg;

    // One classified conversion waiting for the divider
    typedef struct packed {
        logic [MagW-1:0] mag;      // source magnitude before scaling
        logic            neg;      // result is negative (differential only)
        logic            is_diff;
        logic            bipolar;
        logic [MvW-1:0]  vref;     // never zero
        logic            missing;
        logic            adjust;
    } t_conv;

    typedef struct packed {
        logic busy;
    } t_front_stat;

    typedef struct packed {
        logic [QCntW-1:0] count;
        logic             full;
        logic             empty;
    } t_queue_stat;

    typedef struct packed {
        logic busy;
        logic finishing;
    } t_back_stat;

endpackage

// ===== hdl/acs_front.sv =====
// Front end: accepts requests, updates the channel store and temperature value,
// and turns conversions into a source magnitude plus reference. Uses acs_pkg.
module acs_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [acs_pkg::ChFieldW-1:0]      i_channel,
    input  logic [acs_pkg::ChFieldW-1:0]      i_neg_channel,
    input  logic [15:0]                       i_sample,
    input  logic [2:0]                        i_mux_kind,
    input  logic [15:0]                       i_fixed_mv,
    input  logic [7:0]                        i_gain,
    input  logic [1:0]                        i_ref_kind,
    input  logic [15:0]                       i_ref_mv,
    input  logic                              i_bipolar,
    input  logic                              i_negate,
    input  logic                              i_left_adjust,
    input  acs_pkg::t_cfg                     i_cfg,
    output logic                              o_conv_valid,
    input  logic                              i_conv_ready,
    output acs_pkg::t_conv                    o_conv,
    output acs_pkg::t_front_stat              o_stat
);
    import acs_pkg::*;

    logic [StoreW-1:0]      mem [NumChannels];
    logic [NumChannels-1:0] r_ch_vld;
    logic [StoreW-1:0]      r_temp;

    logic                   r_a_valid;
    logic [StoreW-1:0]      r_a_pos, r_a_neg, r_a_temp;
    logic                   r_a_pos_ok, r_a_neg_ok;
    logic [2:0]             r_a_kind;
    logic [MvW-1:0]         r_a_fixed, r_a_ref_mv;
    logic [GainW-1:0]       r_a_gain;
    logic [1:0]             r_a_ref_kind;
    logic                   r_a_bipolar, r_a_negate, r_a_adjust;

    logic                   accept, conv_acc, pos_in_range, neg_in_range;
    logic [StoreW-1:0]      pos, neg, dmag;
    logic                   dsign;
    logic [GainW-1:0]       gain_eff;
    logic [MagW-1:0]        src;
    logic                   src_missing;
    logic [MvW-1:0]         sel;

    assign accept       = i_in_valid && o_in_ready;
    assign conv_acc     = accept && (i_opcode == OP_CONVERT);
    assign pos_in_range = ({1'b0, i_channel} < (ChFieldW+1)'(NumChannels));
    assign neg_in_range = ({1'b0, i_neg_channel} < (ChFieldW+1)'(NumChannels));
    assign o_in_ready   = !r_a_valid || i_conv_ready;

    // Channel store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_WRITE_CH) && pos_in_range) begin
            mem[i_channel[ChIdxW-1:0]] <= i_sample[StoreW-1:0];
        end
        if (conv_acc) begin
            r_a_pos <= mem[i_channel[ChIdxW-1:0]];
            r_a_neg <= mem[i_neg_channel[ChIdxW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_vld <= '0;
            r_temp   <= '0;
        end else if (accept) begin
            if ((i_opcode == OP_WRITE_CH) && pos_in_range) begin
                r_ch_vld[i_channel[ChIdxW-1:0]] <= 1'b1;
            end
            if (i_opcode == OP_WRITE_TEMP) begin
                r_temp <= i_sample[StoreW-1:0];
            end
        end
    end

    // Stage A: conversion fields held until the queue takes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (conv_acc) begin
            r_a_valid <= 1'b1;
        end else if (i_conv_ready) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (conv_acc) begin
            r_a_pos_ok   <= pos_in_range && r_ch_vld[i_channel[ChIdxW-1:0]];
            r_a_neg_ok   <= neg_in_range && r_ch_vld[i_neg_channel[ChIdxW-1:0]];
            r_a_temp     <= r_temp;
            r_a_kind     <= i_mux_kind;
            r_a_fixed    <= i_fixed_mv;
            r_a_gain     <= i_gain;
            r_a_ref_kind <= i_ref_kind;
            r_a_ref_mv   <= i_ref_mv;
            r_a_bipolar  <= i_bipolar;
            r_a_negate   <= i_negate;
            r_a_adjust   <= i_left_adjust;
        end
    end

    // Classify: source magnitude, sign and reference
    always_comb begin
        pos      = r_a_pos_ok ? r_a_pos : '0;
        neg      = r_a_neg_ok ? r_a_neg : '0;
        dsign    = (pos < neg);
        dmag     = dsign ? (neg - pos) : (pos - neg);
        gain_eff = (r_a_gain == '0) ? GainW'(1) : r_a_gain;
        src_missing = 1'b0;
        case (r_a_kind)
            MUX_SINGLE:      src = MagW'(pos);
            MUX_DIFF:        src = MagW'(dmag) * MagW'(gain_eff);
            MUX_TEMP:        src = MagW'(r_a_temp);
            MUX_FIXED:       src = MagW'(r_a_fixed);
            MUX_VCC_QUARTER: begin
                src         = MagW'(i_cfg.vcc >> VccQuarterSh);
                src_missing = (i_cfg.vcc == '0);
            end
            default:         src = '0;
        endcase
        case (r_a_ref_kind)
            REF_VCC:  sel = i_cfg.vcc;
            REF_AREF: sel = i_cfg.aref;
            REF_AVCC: sel = i_cfg.avcc;
            default:  sel = r_a_ref_mv;
        endcase
    end

    always_comb begin
        o_conv.mag     = src;
        o_conv.is_diff = (r_a_kind == MUX_DIFF);
        o_conv.neg     = (r_a_kind == MUX_DIFF) && (dsign ^ r_a_negate);
        o_conv.bipolar = r_a_bipolar;
        o_conv.vref    = (sel == '0) ? VrefDefault : sel;
        o_conv.missing = src_missing || (sel == '0);
        o_conv.adjust  = r_a_adjust;
    end

    assign o_conv_valid = r_a_valid;
    assign o_stat.busy  = r_a_valid;

endmodule

// ===== hdl/acs_queue.sv =====
// Short FIFO of classified conversions between front and back.
// Uses acs_pkg for the entry type and depth.
module acs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  acs_pkg::t_conv        i_push_data,
    input  logic                  i_pop,
    output acs_pkg::t_conv        o_head,
    output acs_pkg::t_queue_stat  o_stat
);
    import acs_pkg::*;

    t_conv            r_slot [QueueDepth];
    logic [QPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCntW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == QCntW'(QueueDepth));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== hdl/acs_back.sv =====
// Back end: scales a queued conversion, divides it by the reference one
// quotient bit per cycle, clips and formats the result. Uses acs_pkg.
module acs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  acs_pkg::t_conv        i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_result_word,
    output logic                  o_clipped,
    output logic                  o_missing_supply,
    output acs_pkg::t_back_stat   o_stat
);
    import acs_pkg::*;

    t_back_state        r_state, n_state;
    logic [DivW-1:0]    r_dq;       // dividend shifts out, quotient shifts in
    logic [MvW-1:0]     r_rem;
    logic [MvW-1:0]     r_vref;
    logic [DivCntW-1:0] r_cnt;
    logic               r_neg, r_is_diff, r_bipolar, r_missing, r_adjust;
    logic               r_out_valid;

    logic               load, step, last, out_load;
    logic [DivW-1:0]    scaled;
    logic [MvW:0]       rem_sh;
    logic               qbit;
    logic [ResW-1:0]    val, q_lo, q_neg;
    logic               clip, over9, over10;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: if (i_head_valid) n_state = BS_DIV;
            BS_DIV:  if (last) n_state = BS_DONE;
            BS_DONE: if (!r_out_valid || i_out_ready) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        load     = 1'b0;
        step     = 1'b0;
        out_load = 1'b0;
        case (r_state)
            BS_IDLE: load = i_head_valid;
            BS_DIV:  step = 1'b1;
            BS_DONE: out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign o_pop            = load;
    assign last             = (r_cnt == DivCntW'(DivW - 1));
    assign o_stat.busy      = (r_state != BS_IDLE);
    assign o_stat.finishing = (r_state == BS_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // magnitude * 511 or * 1023 by shift and subtract
    always_comb begin
        if (i_head.is_diff && i_head.bipolar) begin
            scaled = DivW'({i_head.mag, 9'b0}) - DivW'(i_head.mag);
        end else begin
            scaled = DivW'({i_head.mag, 10'b0}) - DivW'(i_head.mag);
        end
        rem_sh = {r_rem, r_dq[DivW-1]};
        qbit   = (rem_sh >= {1'b0, r_vref});
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dq      <= scaled;
            r_rem     <= '0;
            r_cnt     <= '0;
            r_vref    <= i_head.vref;
            r_neg     <= i_head.neg;
            r_is_diff <= i_head.is_diff;
            r_bipolar <= i_head.bipolar;
            r_missing <= i_head.missing;
            r_adjust  <= i_head.adjust;
        end else if (step) begin
            r_rem <= qbit ? MvW'(rem_sh - {1'b0, r_vref}) : MvW'(rem_sh);
            r_dq  <= {r_dq[DivW-2:0], qbit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Clip and encode; r_dq holds the truncated quotient magnitude here
    always_comb begin
        q_lo   = r_dq[ResW-1:0];
        q_neg  = ResW'(0) - q_lo;
        over9  = (r_dq > DivW'(Scale9));
        over10 = (r_dq > DivW'(Scale10));
        clip   = 1'b0;
        val    = q_lo;
        if (!r_is_diff) begin
            clip = over10;
            val  = over10 ? Scale10 : q_lo;
        end else if (r_bipolar) begin
            clip = over9;
            if (r_neg) begin
                val = over9 ? NegClip : q_neg;
            end else begin
                val = over9 ? Scale9 : q_lo;
            end
        end else begin
            clip = over10 || (r_neg && (r_dq != '0));
            val  = clip ? Scale9 : q_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_result_word    <= r_adjust ? {val, AdjShift'(0)} : WordW'(val);
            o_clipped        <= clip;
            o_missing_supply <= r_missing;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/adc_conversion_scaler.sv =====
// Top level of the ADC conversion scaler: configuration registers, front end,
// queue and divider back end. Depends on acs_pkg, acs_front, acs_queue, acs_back.
//
// Usage:
//  - Input channel (i_in_valid/o_in_ready): each request either writes a
//    channel sample (opcode 0), writes the temperature value (opcode 1), or
//    starts a conversion (opcode 2). Writes produce no output; opcode 3 is dropped.
//  - Output channel (o_out_valid/i_out_ready): one request per conversion with
//    the 16-bit ADC word, a clip flag and a missing-supply flag, in order.
//  - Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 VCC,
//    1 AREF, 2 AVCC in mV; other indices are ignored. Write only while idle.
//  - The bit-serial divider yields a 34-bit quotient and takes a new conversion
//    only after it has finished and handed off the last one.
//  - The two-entry queue lets the front keep taking requests while the divider
//    works or a result waits; when the receiver stalls the divider holds its
//    finished result, then the queue fills, then o_in_ready drops.
//  - Synchronous active-low reset clears config registers, the channel store
//    (all channels read zero), the temperature value and all handshakes.
module adc_conversion_scaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_channel,
    input  logic [3:0]  i_neg_channel,
    input  logic [15:0] i_sample,
    input  logic [2:0]  i_mux_kind,
    input  logic [15:0] i_fixed_mv,
    input  logic [7:0]  i_gain,
    input  logic [1:0]  i_ref_kind,
    input  logic [15:0] i_ref_mv,
    input  logic        i_bipolar,
    input  logic        i_negate,
    input  logic        i_left_adjust,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_result_word,
    output logic        o_clipped,
    output logic        o_missing_supply
);
    import acs_pkg::*;

    t_cfg        r_cfg;
    t_conv       conv, head;
    logic        conv_valid, push, pop;
    t_front_stat fstat;
    t_queue_stat qstat;
    t_back_stat  bstat;

    assign o_cfg_ready = 1'b1;

    // Config registers; unknown indices fall through untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_VCC:  r_cfg.vcc  <= i_cfg_data;
                CFG_AREF: r_cfg.aref <= i_cfg_data;
                CFG_AVCC: r_cfg.avcc <= i_cfg_data;
                default:  r_cfg <= r_cfg;
            endcase
        end
    end

    acs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_neg_channel (i_neg_channel),
        .i_sample      (i_sample),
        .i_mux_kind    (i_mux_kind),
        .i_fixed_mv    (i_fixed_mv),
        .i_gain        (i_gain),
        .i_ref_kind    (i_ref_kind),
        .i_ref_mv      (i_ref_mv),
        .i_bipolar     (i_bipolar),
        .i_negate      (i_negate),
        .i_left_adjust (i_left_adjust),
        .i_cfg         (r_cfg),
        .o_conv_valid  (conv_valid),
        .i_conv_ready  (!qstat.full),
        .o_conv        (conv),
        .o_stat        (fstat)
    );

    assign push = conv_valid && !qstat.full;

    acs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (conv),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (qstat)
    );

    acs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (!qstat.empty),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_word    (o_result_word),
        .o_clipped        (o_clipped),
        .o_missing_supply (o_missing_supply),
        .o_stat           (bstat)
    );

`ifndef SYNTHESIS
    // Queue occupancy never passes its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= QCntW'(QueueDepth))
        else $error("conversion queue overflow");

    // An accepted conversion is held in the front stage on the next cycle
    a_conv_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OP_CONVERT)) |=> fstat.busy)
        else $error("accepted conversion was lost in the front end");

    // A new result only appears right after the divider finished
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(bstat.finishing))
        else $error("result shown without a finished division");

    // Clipped results always carry one of the clip codes
    a_clip_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_result_word == WordW'(Scale9)) || (o_result_word == WordW'(Scale10)) ||
            (o_result_word == WordW'(NegClip)) ||
            (o_result_word == {Scale9, AdjShift'(0)}) ||
            (o_result_word == {Scale10, AdjShift'(0)}) ||
            (o_result_word == {NegClip, AdjShift'(0)}))
        else $error("clipped result with a non-clip code");
`endif

endmodule

// ===== test/acs_result_checker.sv =====
// Result checker for the ADC conversion scaler: watches the config, input and
// result channels, predicts each conversion and compares it. Depends on acs_pkg.
`timescale 1ns / 100ps

module acs_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_channel,
    input  logic [3:0]  i_neg_channel,
    input  logic [15:0] i_sample,
    input  logic [2:0]  i_mux_kind,
    input  logic [15:0] i_fixed_mv,
    input  logic [7:0]  i_gain,
    input  logic [1:0]  i_ref_kind,
    input  logic [15:0] i_ref_mv,
    input  logic        i_bipolar,
    input  logic        i_negate,
    input  logic        i_left_adjust,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_result_word,
    input  logic        i_clipped,
    input  logic        i_missing_supply,
    output int          o_errors,
    output int          o_outstanding,
    output int          o_checked
);
    import acs_pkg::*;

    localparam int ReportLimit = 10;

    typedef struct packed {
        logic [WordW-1:0] word;
        logic             clip;
        logic             missing;
    } t_scaled;

    logic [MvW-1:0]    vcc_mv;
    logic [MvW-1:0]    aref_mv;
    logic [MvW-1:0]    avcc_mv;
    logic [StoreW-1:0] mv_store [NumChannels];
    logic [StoreW-1:0] temp_mv;
    t_scaled           scaled_q [$];
    int                errors;
    int                checked;

    function automatic longint stored_mv(input logic [3:0] ch);
        if (int'(ch) >= NumChannels)
            return 0;
        return longint'(mv_store[ch]);
    endfunction

    // Expected result of the conversion request on the input ports right now.
    function automatic t_scaled scaled_result();
        t_scaled         res;
        longint          src;
        longint          vref;
        longint          q;
        longint          gain_f;
        longint          full_scale;
        longint          half_scale;
        longint          neg_code;
        logic [MvW-1:0]  sel;
        logic [ResW-1:0] code;
        res        = '0;
        src        = 0;
        full_scale = Scale10;
        half_scale = Scale9;
        neg_code   = NegClip;
        gain_f     = (i_gain == '0) ? 1 : i_gain;

        case (i_mux_kind)
            MUX_SINGLE: src = stored_mv(i_channel);
            MUX_DIFF:   src = (stored_mv(i_channel) - stored_mv(i_neg_channel)) * gain_f;
            MUX_TEMP:   src = temp_mv;
            MUX_FIXED:  src = i_fixed_mv;
            MUX_VCC_QUARTER: begin
                if (vcc_mv == '0)
                    res.missing = 1'b1;
                else
                    src = vcc_mv >> VccQuarterSh;
            end
            default:    src = 0;
        endcase

        case (i_ref_kind)
            REF_VCC:  sel = vcc_mv;
            REF_AREF: sel = aref_mv;
            REF_AVCC: sel = avcc_mv;
            default:  sel = i_ref_mv;
        endcase
        if (sel == '0) begin
            res.missing = 1'b1;
            vref        = VrefDefault;
        end else begin
            vref = sel;
        end

        // signed division, truncates toward zero
        if (i_mux_kind == MUX_DIFF) begin
            if (i_negate)
                src = -src;
            if (i_bipolar) begin
                q = (src * half_scale) / vref;
                if (q > half_scale) begin
                    q        = half_scale;
                    res.clip = 1'b1;
                end else if (q < -half_scale) begin
                    q        = neg_code;
                    res.clip = 1'b1;
                end
            end else begin
                q = (src * full_scale) / vref;
                if (q < 0 || q > full_scale) begin
                    q        = half_scale;
                    res.clip = 1'b1;
                end
            end
        end else begin
            q = (src * full_scale) / vref;
            if (q < 0 || q > full_scale) begin
                q        = full_scale;
                res.clip = 1'b1;
            end
        end

        code     = q[ResW-1:0];
        res.word = i_left_adjust ? (WordW'(code) << AdjShift) : WordW'(code);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_scaled want;
        t_scaled seen;
        if (!i_rst_n) begin
            vcc_mv  = '0;
            aref_mv = '0;
            avcc_mv = '0;
            temp_mv = '0;
            foreach (mv_store[k])
                mv_store[k] = '0;
            scaled_q.delete();
            errors  = 0;
            checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VCC:  vcc_mv  = i_cfg_data;
                    CFG_AREF: aref_mv = i_cfg_data;
                    CFG_AVCC: avcc_mv = i_cfg_data;
                    default:  ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                seen = '{i_result_word, i_clipped, i_missing_supply};
                if (scaled_q.size() == 0) begin
                    if (errors < ReportLimit)
                        $display("%0t: result with none pending: word %h clip %b miss %b",
                                 $realtime, seen.word, seen.clip, seen.missing);
                    errors++;
                end else begin
                    want = scaled_q.pop_front();
                    checked++;
                    if (seen.word !== want.word || seen.clip !== want.clip ||
                        seen.missing !== want.missing) begin
                        if (errors < ReportLimit) begin
                            $write("%0t: result %0d mismatch: ", $realtime, checked);
                            $display("word %h/%h clip %b/%b miss %b/%b (expected/actual)",
                                     want.word, seen.word, want.clip, seen.clip,
                                     want.missing, seen.missing);
                        end
                        errors++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (i_opcode)
                    OP_WRITE_CH: begin
                        if (int'(i_channel) < NumChannels)
                            mv_store[i_channel] = StoreW'(i_sample);
                    end
                    OP_WRITE_TEMP: temp_mv = StoreW'(i_sample);
                    OP_CONVERT:    scaled_q.push_back(scaled_result());
                    default:       ;
                endcase
            end
        end
        o_errors      <= errors;
        o_outstanding <= scaled_q.size();
        o_checked     <= checked;
    end

endmodule

// ===== test/tb_adc_conversion_scaler.sv =====
// Top of the ADC conversion scaler testbench: clock, reset, request stimulus,
// supply settings, result back-pressure and verdict. Depends on acs_pkg,
// acs_result_checker and the adc_conversion_scaler RTL.
`timescale 1ns / 100ps

module tb_adc_conversion_scaler;
    import acs_pkg::*;

    localparam int NumPhases     = 6;
    localparam int ItemsPerPhase = 250;
    localparam int MaxGap        = 13;
    localparam int SettleCycles  = 48;     // settle time after the last result is back
    localparam int HoldCycles    = 300;    // long receiver hold-off
    localparam int WatchdogLimit = 3000;   // cycles without any accepted request
    localparam logic [1:0] CfgSpare = 2'd3;  // unmapped register index, must be ignored

    // One input request as driven onto the ports
    typedef struct {
        t_opcode     op;
        logic [3:0]  pos_ch;
        logic [3:0]  neg_ch;
        logic [15:0] sample;
        logic [2:0]  kind;
        logic [15:0] fixed_mv;
        logic [7:0]  gain;
        t_ref_kind   refk;
        logic [15:0] ref_mv;
        logic        bip;
        logic        invert;
        logic        adj;
    } t_req;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  req_opcode    = '0;
    logic [3:0]  req_channel   = '0;
    logic [3:0]  req_neg_ch    = '0;
    logic [15:0] req_sample    = '0;
    logic [2:0]  req_mux_kind  = '0;
    logic [15:0] req_fixed_mv  = '0;
    logic [7:0]  req_gain      = '0;
    logic [1:0]  req_ref_kind  = '0;
    logic [15:0] req_ref_mv    = '0;
    logic        req_bipolar   = 1'b0;
    logic        req_negate    = 1'b0;
    logic        req_left_adj  = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [15:0] result_word;
    logic        clipped;
    logic        missing_supply;

    int errors;
    int outstanding;
    int checked;
    int sent       = 0;
    int idle_count = 0;

    // Shared knobs between the sender and the receiver processes
    bit tx_steady = 1'b0;   // sender offers back to back
    bit rx_steady = 1'b0;   // receiver never stalls
    bit rx_hold   = 1'b0;   // receiver does one long hold-off

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    adc_conversion_scaler dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (req_opcode),
        .i_channel        (req_channel),
        .i_neg_channel    (req_neg_ch),
        .i_sample         (req_sample),
        .i_mux_kind       (req_mux_kind),
        .i_fixed_mv       (req_fixed_mv),
        .i_gain           (req_gain),
        .i_ref_kind       (req_ref_kind),
        .i_ref_mv         (req_ref_mv),
        .i_bipolar        (req_bipolar),
        .i_negate         (req_negate),
        .i_left_adjust    (req_left_adj),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_word    (result_word),
        .o_clipped        (clipped),
        .o_missing_supply (missing_supply)
    );

    acs_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (req_opcode),
        .i_channel        (req_channel),
        .i_neg_channel    (req_neg_ch),
        .i_sample         (req_sample),
        .i_mux_kind       (req_mux_kind),
        .i_fixed_mv       (req_fixed_mv),
        .i_gain           (req_gain),
        .i_ref_kind       (req_ref_kind),
        .i_ref_mv         (req_ref_mv),
        .i_bipolar        (req_bipolar),
        .i_negate         (req_negate),
        .i_left_adjust    (req_left_adj),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_word    (result_word),
        .i_clipped        (clipped),
        .i_missing_supply (missing_supply),
        .o_errors         (errors),
        .o_outstanding    (outstanding),
        .o_checked        (checked)
    );

    // Millivolt value: full range, low ranges that scale without clipping,
    // the extremes, or values near typical supplies.
    function automatic logic [15:0] pick_mv();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 4095));
            2:       return 16'($urandom_range(0, 255));
            3: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'h0001;
                    2:       return 16'hfffe;
                    default: return 16'hffff;
                endcase
            end
            default: return 16'($urandom_range(3000, 5500));
        endcase
    endfunction

    // Mostly conversions with a bias toward differential; some writes,
    // a few dropped opcodes and unknown mux kinds.
    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.op = OP_WRITE_CH;
        else if (pick < 36)
            r.op = OP_WRITE_TEMP;
        else if (pick < 96)
            r.op = OP_CONVERT;
        else
            r.op = OP_IGNORE;
        r.pos_ch = 4'($urandom_range(0, 15));
        r.neg_ch = 4'($urandom_range(0, 15));
        r.sample = pick_mv();
        pick     = $urandom_range(0, 19);
        if (pick < 8)
            r.kind = MUX_DIFF;
        else if (pick < 18)
            r.kind = 3'($urandom_range(MUX_SINGLE, MUX_VCC_QUARTER));
        else
            r.kind = 3'($urandom_range(MUX_VCC_QUARTER + 1, 7));
        r.fixed_mv = pick_mv();
        case ($urandom_range(0, 7))
            0:       r.gain = 8'd0;
            1:       r.gain = 8'd1;
            2:       r.gain = 8'hff;
            3, 4:    r.gain = 8'($urandom_range(1, 8));
            default: r.gain = 8'($urandom_range(0, 255));
        endcase
        r.refk   = t_ref_kind'($urandom_range(0, 3));
        r.ref_mv = ($urandom_range(0, 9) == 0) ? 16'd0 : pick_mv();
        r.bip    = 1'($urandom_range(0, 1));
        r.invert = 1'($urandom_range(0, 1));
        r.adj    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Offer one request and hold it until accepted. Valid stays up between
    // requests when no gap is drawn.
    task automatic send_req(input t_req r);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_opcode   <= r.op;
        req_channel  <= r.pos_ch;
        req_neg_ch   <= r.neg_ch;
        req_sample   <= r.sample;
        req_mux_kind <= r.kind;
        req_fixed_mv <= r.fixed_mv;
        req_gain     <= r.gain;
        req_ref_kind <= r.refk;
        req_ref_mv   <= r.ref_mv;
        req_bipolar  <= r.bip;
        req_negate   <= r.invert;
        req_left_adj <= r.adj;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic put_sample(input t_opcode op, input logic [3:0] ch,
                              input logic [15:0] mv);
        t_req r;
        r        = random_req();
        r.op     = op;
        r.pos_ch = ch;
        r.sample = mv;
        send_req(r);
    endtask

    // flags = {bipolar, negate, left_adjust}
    task automatic convert(input logic [2:0] kind, input logic [3:0] pos, input logic [3:0] neg,
                           input logic [7:0] gain, input t_ref_kind refk,
                           input logic [15:0] refv, input logic [15:0] fixed,
                           input logic [2:0] flags);
        t_req r;
        r          = random_req();
        r.op       = OP_CONVERT;
        r.kind     = kind;
        r.pos_ch   = pos;
        r.neg_ch   = neg;
        r.gain     = gain;
        r.refk     = refk;
        r.ref_mv   = refv;
        r.fixed_mv = fixed;
        {r.bip, r.invert, r.adj} = flags;
        send_req(r);
    endtask

    // Wait out every pending result, then let the pipeline go quiet.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Program all three supplies plus one write to the unmapped index.
    task automatic set_supplies(input logic [15:0] vcc, input logic [15:0] aref,
                                input logic [15:0] avcc);
        write_reg(CFG_VCC, vcc);
        write_reg(CFG_AREF, aref);
        write_reg(CFG_AVCC, avcc);
        write_reg(CfgSpare, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    // Result sink: random stall per result, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (rx_hold) begin
                out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                rx_hold = 1'b0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, MaxGap);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: any accepted request on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= WatchdogLimit) begin
            $display("watchdog: no request accepted for %0d cycles", idle_count);
            $display("adc_conversion_scaler verification failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin : stimulus
        logic [15:0] vcc_set  [NumPhases];
        logic [15:0] aref_set [NumPhases];
        logic [15:0] avcc_set [NumPhases];
        t_req        r;
        int          phase;
        int          n;
        int          k;

        // Supply settings per random phase: typical, all maximum, all minimum,
        // all missing, random, and a mix with AREF missing.
        vcc_set  = '{16'd5000, 16'hffff, 16'd1, 16'd0, 16'd0, 16'd3300};
        aref_set = '{16'd2560, 16'hffff, 16'd1, 16'd0, 16'd0, 16'd0};
        avcc_set = '{16'd5000, 16'hffff, 16'd1, 16'd0, 16'd0, 16'hffff};
        vcc_set[4]  = 16'($urandom_range(1, 65535));
        aref_set[4] = 16'($urandom_range(1, 65535));
        avcc_set[4] = 16'($urandom_range(1, 65535));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with all supplies still at their reset value of zero.
        put_sample(OP_WRITE_CH, 4'd0, 16'hffff);
        put_sample(OP_WRITE_CH, 4'd15, 16'd1);
        put_sample(OP_WRITE_CH, 4'd1, 16'd0);
        put_sample(OP_WRITE_CH, 4'd2, 16'h8000);
        put_sample(OP_WRITE_TEMP, 4'd7, 16'hffff);
        // single channel: clip against a 1 mV reference, exact full scale
        convert(MUX_SINGLE, 4'd0, 4'd0, 8'd1, REF_FIXED, 16'd1, 16'd0, 3'b000);
        convert(MUX_SINGLE, 4'd0, 4'd0, 8'd1, REF_FIXED, 16'hffff, 16'd0, 3'b001);
        // zero fixed reference falls back to the default reference
        convert(MUX_SINGLE, 4'd15, 4'd0, 8'd1, REF_FIXED, 16'd0, 16'd0, 3'b000);
        // supplies missing for each selectable reference
        convert(MUX_SINGLE, 4'd2, 4'd0, 8'd1, REF_VCC, 16'd1000, 16'd0, 3'b000);
        convert(MUX_DIFF, 4'd0, 4'd1, 8'hff, REF_AREF, 16'd0, 16'd0, 3'b100);
        convert(MUX_DIFF, 4'd0, 4'd1, 8'hff, REF_AREF, 16'd0, 16'd0, 3'b110);
        convert(MUX_DIFF, 4'd1, 4'd0, 8'd1, REF_AVCC, 16'd0, 16'd0, 3'b000);
        // small negative bipolar value kept as two's complement; zero gain
        convert(MUX_DIFF, 4'd1, 4'd15, 8'd0, REF_FIXED, 16'd511, 16'd0, 3'b100);
        convert(MUX_DIFF, 4'd15, 4'd1, 8'd200, REF_FIXED, 16'hffff, 16'd0, 3'b001);
        convert(MUX_DIFF, 4'd15, 4'd15, 8'hff, REF_FIXED, 16'd1000, 16'd0, 3'b111);
        convert(MUX_TEMP, 4'd0, 4'd0, 8'd1, REF_FIXED, 16'hffff, 16'd0, 3'b001);
        convert(MUX_FIXED, 4'd0, 4'd0, 8'd1, REF_FIXED, 16'd1000, 16'd0, 3'b000);
        convert(MUX_FIXED, 4'd0, 4'd0, 8'd1, REF_FIXED, 16'hffff, 16'hffff, 3'b001);
        // VCC/4 with VCC missing
        convert(MUX_VCC_QUARTER, 4'd0, 4'd0, 8'd1, REF_FIXED, 16'd5000, 16'd0, 3'b000);
        // mux kinds past the defined ones read as a zero source
        for (k = MUX_VCC_QUARTER + 1; k < 8; k++)
            convert(3'(k), 4'd0, 4'd0, 8'd1, REF_FIXED, 16'd100, 16'd0, 3'b000);
        r    = random_req();
        r.op = OP_IGNORE;
        send_req(r);
        drain();

        // Random phases, one supply setting each
        for (phase = 0; phase < NumPhases; phase++) begin
            set_supplies(vcc_set[phase], aref_set[phase], avcc_set[phase]);
            rx_steady = (phase == 1) || (phase == 3);
            for (n = 0; n < ItemsPerPhase; n++) begin
                r = random_req();
                // long hold-off: receiver stops while conversions keep coming
                if (phase == 4 && n == 60)
                    rx_hold = 1'b1;
                tx_steady = (phase == 1) || (phase == 2) || (phase == 4 && n >= 60 && n < 80);
                if (phase == 4 && n >= 60 && n < 80)
                    r.op = OP_CONVERT;
                // sender pauses mid-phase until every result is back
                if (phase == 5 && n == 125)
                    drain();
                send_req(r);
            end
            drain();
        end

        $display("%0d requests sent, %0d conversion results compared", sent, checked);
        $display("covered reset supplies plus %0d settings, long result hold-off included",
                 NumPhases);
        if (errors == 0) begin
            $display("adc_conversion_scaler verification clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("adc_conversion_scaler verification failed");
        end
        $finish;
    end

endmodule
